### rtl/lbr_pkg.sv
// Shared types, float constants and rounding helpers for the look-direction basis block.
// Used by lbr_fmul, lbr_fadd and look_direction_basis_fast_rsqrt; depends on nothing.
package lbr_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [2:0] vec_type;
   typedef word_type [5:0] six_type;

   localparam int Stages = 15;

   localparam word_type MAGIC_SEED  = 32'h5F37_5A00;
   localparam word_type F_ZERO      = 32'h0000_0000;
   localparam word_type F_ONE       = 32'h3F80_0000;
   localparam word_type F_THREE     = 32'h4040_0000;
   localparam word_type F_TWELVE    = 32'h4140_0000;
   localparam word_type F_SIXTEENTH = 32'h3D80_0000;
   localparam word_type F_INF_MAG   = 32'h7F80_0000;
   localparam word_type QUIET_BIT   = 32'h0040_0000;
   localparam word_type DEFAULT_NAN = 32'hFFC0_0000;

   // Count leading zeros of a 51-bit word (value assumed nonzero).
   function automatic logic [5:0] clz51(input logic [50:0] v);
      logic [5:0] n;
      logic       found;
      n     = 6'd0;
      found = 1'b0;
      for (int i = 50; i >= 0; i--) begin
         if (!found && v[i]) begin
            found = 1'b1;
         end else if (!found) begin
            n = n + 6'd1;
         end
      end
      return n;
   endfunction

   // Round a normalized significand (leading one at bit 47) to nearest even.
   // be is the biased exponent before any subnormal shift.
   function automatic word_type fp_round(input logic sign, input logic signed [11:0] be,
                                         input logic [47:0] sig, input logic stk);
      logic [47:0] sh_sig;
      logic [47:0] mask;
      logic [11:0] shamt;
      logic        st;
      logic [7:0]  ef;
      logic        inc;
      logic [30:0] sum;
      word_type    res;
      sh_sig = sig;
      mask   = '0;
      shamt  = '0;
      st     = stk;
      ef     = 8'd0;
      if (be >= 12'sd255) begin
         res = {sign, F_INF_MAG[30:0]};
      end else begin
         if (be <= 12'sd0) begin
            shamt = 12'd1 - be;
            if (shamt >= 12'd48) begin
               sh_sig = '0;
               st     = stk | (|sig);
            end else begin
               mask   = (48'h1 << shamt[5:0]) - 48'h1;
               sh_sig = sig >> shamt[5:0];
               st     = stk | (|(sig & mask));
            end
            ef = 8'd0;
         end else begin
            ef = be[7:0];
         end
         inc = sh_sig[23] & (st | (|sh_sig[22:0]) | sh_sig[24]);
         sum = {ef, sh_sig[46:24]} + {30'd0, inc};
         res = {sign, sum};
      end
      return res;
   endfunction

endpackage

### rtl/look_direction_basis_fast_rsqrt.sv
// Top level of the look-direction basis block: fifteen-stage float pipeline.
// Depends on lbr_pkg, lbr_fmul and lbr_fadd.
//
// Takes one direction word (three IEEE single components) per cycle while not
// stalled and returns the forward, right and up rows of a look-at basis as nine
// IEEE single words. Forward is the direction scaled by a fast inverse square root
// of its squared length (magic-constant seed, then two folded Newton steps), or by
// +0 when the squared length is not greater than zero. Right is forward cross
// (0,1,0); up is right cross forward. Every operation rounds to nearest even with
// full subnormal, infinity and NaN handling. Each stage holds one level of
// dependent float operations (one multiply or one add per path). Each stage
// advances on its own when the stage after it is empty or moving, so bubbles
// close up while the output is stalled and req_stall rises only when all
// fifteen stages hold a word.
module look_direction_basis_fast_rsqrt import lbr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_dir_x,
   input  logic [31:0] req_dir_y,
   input  logic [31:0] req_dir_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_fwd_x,
   output logic [31:0] rsp_fwd_y,
   output logic [31:0] rsp_fwd_z,
   output logic [31:0] rsp_side_x,
   output logic [31:0] rsp_side_y,
   output logic [31:0] rsp_side_z,
   output logic [31:0] rsp_top_x,
   output logic [31:0] rsp_top_y,
   output logic [31:0] rsp_top_z
);

   // Stage valid bits and per-stage advance.
   logic [Stages:1]   v_ff;
   logic [Stages:1]   v_in;
   logic [Stages+1:1] adv;

   always_comb begin
      adv[Stages+1] = !rsp_stall;
      for (int k = Stages; k >= 1; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      v_in = {v_ff[Stages-1:1], req_valid};
   end

   assign req_stall = !adv[1];
   assign rsp_valid = v_ff[Stages];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= Stages; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   vec_type  dir_in;
   assign dir_in = {req_dir_z, req_dir_y, req_dir_x};

   // Stage 1: squares of the components.
   vec_type  d1_ff, sq1_ff, sq1_in;
   // Stage 2: partial sum x*x + y*y.
   vec_type  d2_ff;
   word_type szz2_ff, acc2_ff, acc2_in;
   // Stage 3: squared length.
   vec_type  d3_ff;
   word_type len3_ff, len3_in;
   // Stage 4: seed and p = L*g.
   vec_type  d4_ff;
   logic     pos4_ff, pos4_in;
   word_type g4_ff, g4_in, p4_ff, p4_in;
   // Stage 5: h = g*p, a = 0.0625*g.
   vec_type  d5_ff;
   logic     pos5_ff;
   word_type h5_ff, h5_in, a5_ff, a5_in;
   // Stage 6: n = 3 - h.
   vec_type  d6_ff;
   logic     pos6_ff;
   word_type n6_ff, n6_in, h6_ff, a6_ff;
   // Stage 7: hn = h*n, b = a*n.
   vec_type  d7_ff;
   logic     pos7_ff;
   word_type hn7_ff, hn7_in, b7_ff, b7_in, n7_ff;
   // Stage 8: t = n*hn.
   vec_type  d8_ff;
   logic     pos8_ff;
   word_type t8_ff, t8_in, b8_ff;
   // Stage 9: neg = -(t - 12).
   vec_type  d9_ff;
   logic     pos9_ff;
   word_type c9_in, neg9_ff, b9_ff;
   // Stage 10: scale.
   vec_type  d10_ff;
   word_type s10_ff, s10_in;
   // Stages 11 to 15: forward, cross products.
   vec_type  a11_ff, a11_in;
   vec_type  a12_ff;
   six_type  m12_ff, m12_in;
   vec_type  a13_ff, r13_ff, r13_in;
   vec_type  a14_ff, r14_ff;
   six_type  k14_ff, k14_in;
   vec_type  a15_ff, r15_ff, t15_ff, t15_in;

   vec_type  m_a, m_b, k_a, k_b;

   genvar i;
   generate
      for (i = 0; i < 3; i++) begin : g_vec
         lbr_fmul u_sq  (.op_a(dir_in[i]), .op_b(dir_in[i]), .res(sq1_in[i]));
         lbr_fmul u_fwd (.op_a(d10_ff[i]), .op_b(s10_ff),    .res(a11_in[i]));
         lbr_fmul u_m1  (.op_a(m_a[i]),    .op_b(m_b[i]),    .res(m12_in[2*i]));
         lbr_fadd u_r   (.op_a(m12_ff[2*i]), .op_b(m12_ff[2*i+1]), .sub(1'b1),
                         .res(r13_in[i]));
         lbr_fmul u_k1  (.op_a(k_a[i]),    .op_b(k_b[i]),    .res(k14_in[2*i]));
         lbr_fadd u_t   (.op_a(k14_ff[2*i]), .op_b(k14_ff[2*i+1]), .sub(1'b1),
                         .res(t15_in[i]));
      end
   endgenerate

   // Right row: m pairs are (ay*0, az*1), (az*0, ax*0), (ax*1, ay*0).
   lbr_fmul u_m0 (.op_a(a11_ff[2]), .op_b(F_ONE),  .res(m12_in[1]));
   lbr_fmul u_m2 (.op_a(a11_ff[0]), .op_b(F_ZERO), .res(m12_in[3]));
   lbr_fmul u_m4 (.op_a(a11_ff[1]), .op_b(F_ZERO), .res(m12_in[5]));
   assign m_a = {a11_ff[0], a11_ff[2], a11_ff[1]};
   assign m_b = {F_ONE, F_ZERO, F_ZERO};
   // The second products of the right row multiply by the up axis.
   // Pairs: (ay*uz, az*uy), (az*ux, ax*uz), (ax*uy, ay*ux).
   // First operands come from m_a/m_b above; u_m0, u_m2 and u_m4 form the second ones.
   // Up row: (ry*az, rz*ay), (rz*ax, rx*az), (rx*ay, ry*ax).
   assign k_a = {r13_ff[0], r13_ff[2], r13_ff[1]};
   assign k_b = {a13_ff[1], a13_ff[0], a13_ff[2]};
   lbr_fmul u_k0 (.op_a(r13_ff[2]), .op_b(a13_ff[1]), .res(k14_in[1]));
   lbr_fmul u_k2 (.op_a(r13_ff[0]), .op_b(a13_ff[2]), .res(k14_in[3]));
   lbr_fmul u_k4 (.op_a(r13_ff[1]), .op_b(a13_ff[0]), .res(k14_in[5]));

   lbr_fadd u_acc (.op_a(sq1_ff[0]), .op_b(sq1_ff[1]), .sub(1'b0), .res(acc2_in));
   lbr_fadd u_len (.op_a(acc2_ff),   .op_b(szz2_ff),   .sub(1'b0), .res(len3_in));
   lbr_fmul u_p   (.op_a(len3_ff),   .op_b(g4_in),     .res(p4_in));
   lbr_fmul u_h   (.op_a(g4_ff),     .op_b(p4_ff),     .res(h5_in));
   lbr_fmul u_a   (.op_a(F_SIXTEENTH), .op_b(g4_ff),   .res(a5_in));
   lbr_fadd u_n   (.op_a(F_THREE),   .op_b(h5_ff),     .sub(1'b1), .res(n6_in));
   lbr_fmul u_hn  (.op_a(h6_ff),     .op_b(n6_ff),     .res(hn7_in));
   lbr_fmul u_b   (.op_a(a6_ff),     .op_b(n6_ff),     .res(b7_in));
   lbr_fmul u_tt  (.op_a(n7_ff),     .op_b(hn7_ff),    .res(t8_in));
   lbr_fadd u_c   (.op_a(t8_ff),     .op_b(F_TWELVE),  .sub(1'b1), .res(c9_in));
   lbr_fmul u_s   (.op_a(b9_ff),     .op_b(neg9_ff),   .res(s10_in));

   // Seed from the bits of the squared length; positive test excludes zero and NaN.
   assign g4_in   = MAGIC_SEED - {1'b0, len3_ff[31:1]};
   assign pos4_in = !len3_ff[31] && (len3_ff[30:0] != 31'd0) &&
                    !((len3_ff[30:23] == 8'hFF) && (len3_ff[22:0] != 23'd0));

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         d1_ff  <= dir_in;
         sq1_ff <= sq1_in;
      end
      if (adv[2]) begin
         d2_ff   <= d1_ff;
         szz2_ff <= sq1_ff[2];
         acc2_ff <= acc2_in;
      end
      if (adv[3]) begin
         d3_ff   <= d2_ff;
         len3_ff <= len3_in;
      end
      if (adv[4]) begin
         d4_ff   <= d3_ff;
         pos4_ff <= pos4_in;
         g4_ff   <= g4_in;
         p4_ff   <= p4_in;
      end
      if (adv[5]) begin
         d5_ff   <= d4_ff;
         pos5_ff <= pos4_ff;
         h5_ff   <= h5_in;
         a5_ff   <= a5_in;
      end
      if (adv[6]) begin
         d6_ff   <= d5_ff;
         pos6_ff <= pos5_ff;
         n6_ff   <= n6_in;
         h6_ff   <= h5_ff;
         a6_ff   <= a5_ff;
      end
      if (adv[7]) begin
         d7_ff   <= d6_ff;
         pos7_ff <= pos6_ff;
         hn7_ff  <= hn7_in;
         b7_ff   <= b7_in;
         n7_ff   <= n6_ff;
      end
      if (adv[8]) begin
         d8_ff   <= d7_ff;
         pos8_ff <= pos7_ff;
         t8_ff   <= t8_in;
         b8_ff   <= b7_ff;
      end
      if (adv[9]) begin
         d9_ff   <= d8_ff;
         pos9_ff <= pos8_ff;
         neg9_ff <= {~c9_in[31], c9_in[30:0]};
         b9_ff   <= b8_ff;
      end
      if (adv[10]) begin
         d10_ff <= d9_ff;
         s10_ff <= pos9_ff ? s10_in : F_ZERO;
      end
      if (adv[11]) begin
         a11_ff <= a11_in;
      end
      if (adv[12]) begin
         a12_ff <= a11_ff;
         m12_ff <= m12_in;
      end
      if (adv[13]) begin
         a13_ff <= a12_ff;
         r13_ff <= r13_in;
      end
      if (adv[14]) begin
         a14_ff <= a13_ff;
         r14_ff <= r13_ff;
         k14_ff <= k14_in;
      end
      if (adv[15]) begin
         a15_ff <= a14_ff;
         r15_ff <= r14_ff;
         t15_ff <= t15_in;
      end
   end

   assign rsp_fwd_x  = a15_ff[0];
   assign rsp_fwd_y  = a15_ff[1];
   assign rsp_fwd_z  = a15_ff[2];
   assign rsp_side_x = r15_ff[0];
   assign rsp_side_y = r15_ff[1];
   assign rsp_side_z = r15_ff[2];
   assign rsp_top_x  = t15_ff[0];
   assign rsp_top_y  = t15_ff[1];
   assign rsp_top_z  = t15_ff[2];

`ifndef NO_ASSERTIONS
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&v_ff))
      else $error("input stalled while a stage is empty");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (v_ff == '0))
      else $error("valid bits not cleared by reset");

   a_move_out: assert property (@(posedge clock) disable iff (reset)
      (v_ff[Stages-1] && !rsp_stall) |=> rsp_valid)
      else $error("word lost before the output stage");

   a_zero_scale: assert property (@(posedge clock) disable iff (reset)
      (adv[10] && v_ff[9] && !pos9_ff) |=> (s10_ff == F_ZERO))
      else $error("scale not zero for a non-positive squared length");
`endif

endmodule

### rtl/lbr_fmul.sv
// Single-precision multiplier, round to nearest even, full subnormal support.
// Depends on lbr_pkg for the rounding and leading-zero helpers.
module lbr_fmul import lbr_pkg::*; (
   input  word_type op_a,
   input  word_type op_b,
   output word_type res
);

   logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sign;
   logic [7:0]         ea, eb;
   logic [23:0]        ma, mb;
   logic [47:0]        prod, norm;
   logic [5:0]         lz;
   logic signed [11:0] be;

   always_comb begin
      a_nan  = (op_a[30:23] == 8'hFF) && (op_a[22:0] != 23'd0);
      b_nan  = (op_b[30:23] == 8'hFF) && (op_b[22:0] != 23'd0);
      a_inf  = (op_a[30:23] == 8'hFF) && (op_a[22:0] == 23'd0);
      b_inf  = (op_b[30:23] == 8'hFF) && (op_b[22:0] == 23'd0);
      a_zero = (op_a[30:0] == 31'd0);
      b_zero = (op_b[30:0] == 31'd0);
      sign   = op_a[31] ^ op_b[31];
      ea     = (op_a[30:23] == 8'd0) ? 8'd1 : op_a[30:23];
      eb     = (op_b[30:23] == 8'd0) ? 8'd1 : op_b[30:23];
      ma     = {(op_a[30:23] != 8'd0), op_a[22:0]};
      mb     = {(op_b[30:23] != 8'd0), op_b[22:0]};
      prod   = 48'(ma) * 48'(mb);
      lz     = clz51({prod, 3'b000});
      norm   = prod << lz;
      be     = $signed(12'(ea) + 12'(eb) - 12'd126 - 12'(lz));
      if (a_nan) begin
         res = op_a | QUIET_BIT;
      end else if (b_nan) begin
         res = op_b | QUIET_BIT;
      end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
         res = DEFAULT_NAN;
      end else if (a_inf || b_inf) begin
         res = {sign, F_INF_MAG[30:0]};
      end else if (a_zero || b_zero) begin
         res = {sign, 31'd0};
      end else begin
         res = fp_round(sign, be, norm, 1'b0);
      end
   end

endmodule

### rtl/lbr_fadd.sv
// Single-precision adder/subtractor, round to nearest even, full subnormal support.
// Depends on lbr_pkg for the rounding and leading-zero helpers.
module lbr_fadd import lbr_pkg::*; (
   input  word_type op_a,
   input  word_type op_b,
   input  logic     sub,
   output word_type res
);

   logic               bs, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, swap;
   logic               xs, ys, st;
   logic [7:0]         xe, ye, d;
   logic [22:0]        xf, yf;
   logic [23:0]        xm, ym;
   logic [49:0]        xw, yw, ysh, ymask;
   logic [50:0]        sum, norm;
   logic [5:0]         lz;
   logic signed [11:0] be;

   always_comb begin
      bs     = op_b[31] ^ sub;
      a_nan  = (op_a[30:23] == 8'hFF) && (op_a[22:0] != 23'd0);
      b_nan  = (op_b[30:23] == 8'hFF) && (op_b[22:0] != 23'd0);
      a_inf  = (op_a[30:23] == 8'hFF) && (op_a[22:0] == 23'd0);
      b_inf  = (op_b[30:23] == 8'hFF) && (op_b[22:0] == 23'd0);
      a_zero = (op_a[30:0] == 31'd0);
      b_zero = (op_b[30:0] == 31'd0);
      // Order the operands by magnitude.
      swap   = op_b[30:0] > op_a[30:0];
      xs     = swap ? bs : op_a[31];
      ys     = swap ? op_a[31] : bs;
      xe     = swap ? op_b[30:23] : op_a[30:23];
      ye     = swap ? op_a[30:23] : op_b[30:23];
      xf     = swap ? op_b[22:0] : op_a[22:0];
      yf     = swap ? op_a[22:0] : op_b[22:0];
      xm     = {(xe != 8'd0), xf};
      ym     = {(ye != 8'd0), yf};
      xe     = (xe == 8'd0) ? 8'd1 : xe;
      ye     = (ye == 8'd0) ? 8'd1 : ye;
      d      = xe - ye;
      xw     = {xm, 26'd0};
      yw     = {ym, 26'd0};
      ymask  = '0;
      if (d >= 8'd50) begin
         ysh = '0;
         st  = |ym;
      end else begin
         ymask = (50'h1 << d[5:0]) - 50'h1;
         ysh   = yw >> d[5:0];
         st    = |(yw & ymask);
      end
      ysh[0] = ysh[0] | st;
      if (xs ^ ys) begin
         sum = {1'b0, xw} - {1'b0, ysh};
      end else begin
         sum = {1'b0, xw} + {1'b0, ysh};
      end
      lz   = clz51(sum);
      norm = sum << lz;
      be   = $signed(12'(xe) + 12'd1 - 12'(lz));
      if (a_nan) begin
         res = op_a | QUIET_BIT;
      end else if (b_nan) begin
         res = op_b | QUIET_BIT;
      end else if (a_inf && b_inf && (op_a[31] != bs)) begin
         res = DEFAULT_NAN;
      end else if (a_inf) begin
         res = op_a;
      end else if (b_inf) begin
         res = {bs, F_INF_MAG[30:0]};
      end else if (a_zero && b_zero) begin
         res = {op_a[31] & bs, 31'd0};
      end else if (sum == 51'd0) begin
         res = F_ZERO;
      end else begin
         res = fp_round(xs, be, norm[50:3], |norm[2:0]);
      end
   end

endmodule

### bench/look_direction_basis_checker.sv
// Checker for the look-direction basis block: watches both channels, predicts each basis
// with a bit-exact single-precision model and compares it. Depends on lbr_pkg.
module look_direction_basis_checker import lbr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_dir_x,
   input  logic [31:0] req_dir_y,
   input  logic [31:0] req_dir_z,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_fwd_x,
   input  logic [31:0] rsp_fwd_y,
   input  logic [31:0] rsp_fwd_z,
   input  logic [31:0] rsp_side_x,
   input  logic [31:0] rsp_side_y,
   input  logic [31:0] rsp_side_z,
   input  logic [31:0] rsp_top_x,
   input  logic [31:0] rsp_top_y,
   input  logic [31:0] rsp_top_z,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      word_type fx, fy, fz, sx, sy, sz, tx, ty, tz;
   } basis_type;

   basis_type basis_queue[$];

   function automatic logic is_nan(input word_type a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 0);
   endfunction

   function automatic logic is_inf(input word_type a);
      return a[30:0] == F_INF_MAG[30:0];
   endfunction

   function automatic logic [63:0] sig_of(input word_type a);
      return (a[30:23] == 0) ? {41'd0, a[22:0]} : {40'd0, 1'b1, a[22:0]};
   endfunction

   function automatic int exp_of(input word_type a);
      return (a[30:23] == 0) ? 1 : int'(a[30:23]);
   endfunction

   // Round m * 2**e to nearest even single precision.
   function automatic word_type fp_pack(input logic sgn, input logic [63:0] m, input int e);
      int          lead, sh, e2, be;
      logic [63:0] q, rem, half;
      lead = 0;
      for (int i = 0; i < 64; i++) if (m[i]) lead = i;
      sh = lead - 23;
      if (-149 - e > sh) sh = -149 - e;
      if (sh >= 64) return {sgn, 31'd0};
      if (sh > 0) begin
         q    = m >> sh;
         rem  = m & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      end else begin
         q = m << (-sh);
      end
      e2 = e + sh;
      if (q[24]) begin
         q  = q >> 1;
         e2 = e2 + 1;
      end
      if (q < 64'h80_0000) return {sgn, q[30:0]};
      be = e2 + 150;
      if (be >= 255) return {sgn, F_INF_MAG[30:0]};
      return {sgn, be[7:0], q[22:0]};
   endfunction

   function automatic word_type fp_mul(input word_type a, input word_type b);
      logic sgn;
      if (is_nan(a)) return a | QUIET_BIT;
      if (is_nan(b)) return b | QUIET_BIT;
      sgn = a[31] ^ b[31];
      if (is_inf(a) || is_inf(b)) begin
         if (a[30:0] == 0 || b[30:0] == 0) return DEFAULT_NAN;
         return {sgn, F_INF_MAG[30:0]};
      end
      if (a[30:0] == 0 || b[30:0] == 0) return {sgn, 31'd0};
      return fp_pack(sgn, sig_of(a) * sig_of(b), exp_of(a) + exp_of(b) - 300);
   endfunction

   // a + b, or a - b when neg is set; NaN operands pass through unflipped.
   function automatic word_type fp_add(input word_type a, input word_type b, input logic neg);
      logic        sa, sb, ss, st;
      logic [63:0] ma, mb, mt, m;
      int          ea, eb, et, d;
      if (is_nan(a)) return a | QUIET_BIT;
      if (is_nan(b)) return b | QUIET_BIT;
      sa = a[31];
      sb = b[31] ^ neg;
      if (is_inf(a)) begin
         if (is_inf(b) && sa != sb) return DEFAULT_NAN;
         return a;
      end
      if (is_inf(b)) return {sb, F_INF_MAG[30:0]};
      if (a[30:0] == 0 && b[30:0] == 0) return {sa & sb, 31'd0};
      if (a[30:0] == 0) return {sb, b[30:0]};
      if (b[30:0] == 0) return a;
      ma = sig_of(a) << 3;
      mb = sig_of(b) << 3;
      ea = exp_of(a);
      eb = exp_of(b);
      if (ea < eb) begin
         mt = ma; ma = mb; mb = mt;
         et = ea; ea = eb; eb = et;
         st = sa; sa = sb; sb = st;
      end
      d = ea - eb;
      if (d > 40) mb = {63'd0, mb != 0};
      else if (d > 0) mb = (mb >> d) | {63'd0, (mb & ((64'd1 << d) - 64'd1)) != 0};
      if (sa == sb) begin
         m  = ma + mb;
         ss = sa;
      end else if (ma >= mb) begin
         m  = ma - mb;
         ss = sa;
      end else begin
         m  = mb - ma;
         ss = sb;
      end
      if (m == 0) return F_ZERO;
      return fp_pack(ss, m, ea - 153);
   endfunction

   function automatic basis_type look_basis(input word_type dx, input word_type dy,
                                            input word_type dz);
      word_type  len_sq, g, h, n, t, c, s;
      basis_type r;
      len_sq = fp_add(fp_add(fp_mul(dx, dx), fp_mul(dy, dy), 1'b0), fp_mul(dz, dz), 1'b0);
      s = F_ZERO;
      if (!is_nan(len_sq) && !len_sq[31] && len_sq[30:0] != 0) begin
         // seed from the bit pattern, then two folded Newton steps
         g = MAGIC_SEED - (len_sq >> 1);
         h = fp_mul(g, fp_mul(len_sq, g));
         n = fp_add(F_THREE, h, 1'b1);
         t = fp_mul(n, fp_mul(h, n));
         c = fp_add(t, F_TWELVE, 1'b1);
         s = fp_mul(fp_mul(fp_mul(F_SIXTEENTH, g), n), {~c[31], c[30:0]});
      end
      r.fx = fp_mul(dx, s);
      r.fy = fp_mul(dy, s);
      r.fz = fp_mul(dz, s);
      r.sx = fp_add(fp_mul(r.fy, F_ZERO), fp_mul(r.fz, F_ONE), 1'b1);
      r.sy = fp_add(fp_mul(r.fz, F_ZERO), fp_mul(r.fx, F_ZERO), 1'b1);
      r.sz = fp_add(fp_mul(r.fx, F_ONE), fp_mul(r.fy, F_ZERO), 1'b1);
      r.tx = fp_add(fp_mul(r.sy, r.fz), fp_mul(r.sz, r.fy), 1'b1);
      r.ty = fp_add(fp_mul(r.sz, r.fx), fp_mul(r.sx, r.fz), 1'b1);
      r.tz = fp_add(fp_mul(r.sx, r.fy), fp_mul(r.sy, r.fx), 1'b1);
      return r;
   endfunction

   task automatic check_field(input string name, input word_type want, input word_type got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      basis_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            basis_queue.push_back(look_basis(req_dir_x, req_dir_y, req_dir_z));
         if (rsp_valid && !rsp_stall) begin
            if (basis_queue.size() == 0) begin
               $error("result word with no expectation waiting");
               fail_count++;
            end else begin
               want = basis_queue.pop_front();
               check_field("fwd_x", want.fx, rsp_fwd_x);
               check_field("fwd_y", want.fy, rsp_fwd_y);
               check_field("fwd_z", want.fz, rsp_fwd_z);
               check_field("side_x", want.sx, rsp_side_x);
               check_field("side_y", want.sy, rsp_side_y);
               check_field("side_z", want.sz, rsp_side_z);
               check_field("top_x", want.tx, rsp_top_x);
               check_field("top_y", want.ty, rsp_top_y);
               check_field("top_z", want.tz, rsp_top_z);
            end
         end
      end
      pending = basis_queue.size();
   end

endmodule

### bench/tb_look_direction_basis_fast_rsqrt.sv
// Top of the look-direction basis testbench: clock, reset, direction stimulus, response
// stalls, watchdog and verdict. Depends on lbr_pkg, the block and the checker module.
module tb_look_direction_basis_fast_rsqrt;
   import lbr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomWords = 430;
   localparam int WatchLimit  = 3000;
   localparam int HoldCycles  = 80;
   localparam int HoldAtWord  = 170;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [31:0] rsp_fwd_x, rsp_fwd_y, rsp_fwd_z;
   logic [31:0] rsp_side_x, rsp_side_y, rsp_side_z;
   logic [31:0] rsp_top_x, rsp_top_y, rsp_top_z;
   int          fail_count, pending;
   int          quiet_cycles = 0;

   always #5 clock = ~clock;

   look_direction_basis_fast_rsqrt dut (.*);
   look_direction_basis_checker checker_i (.*);

   // Random component: ordinary magnitudes half the time, plus raw bits, zeros, specials and
   // exponent extremes so subnormal, overflow and NaN paths all get reached.
   function automatic word_type pick_component();
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return {raw[31], 8'($urandom_range(100, 154)), raw[22:0]};
         5:             return raw;
         6:             return {raw[31], 31'd0};
         7:             return {raw[31], 8'hFF, (raw[1] ? 23'd0 : raw[22:0])};
         8:             return {raw[31], (raw[0] ? 8'd0 : 8'($urandom_range(0, 12))),
                                raw[22:0]};
         default:       return {raw[31], 8'($urandom_range(200, 254)), raw[22:0]};
      endcase
   endfunction

   // Offer one direction word after a gap; hold it until taken.
   task automatic send_dir(input word_type x, input word_type y, input word_type z,
                           input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_dir_x <= x;
      req_dir_y <= y;
      req_dir_z <= z;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Stimulus.
   initial begin
      word_type edge_vals[16];
      int       gap;
      edge_vals = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                    32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFA0_0001,
                    32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
                    32'h1E00_0000, 32'h6000_0000, 32'h4049_0FDB, 32'h0080_0000};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero and signed zero, axis aligned along up (degenerate right),
      // infinities, NaNs, subnormals, squared length that underflows or overflows.
      send_dir(F_ZERO, F_ZERO, F_ZERO, 0);
      send_dir(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      send_dir(F_ONE, F_ZERO, F_ZERO, 1);
      send_dir(F_ZERO, F_ONE, F_ZERO, 0);
      send_dir(F_ZERO, 32'hBF80_0000, F_ZERO, 0);
      send_dir(F_ZERO, F_ZERO, F_ONE, 2);
      send_dir(32'h4040_0000, 32'h4080_0000, 32'hC0A0_0000, 0);
      send_dir(32'h7F80_0000, F_ZERO, F_ONE, 0);
      send_dir(F_ONE, 32'hFF80_0000, 32'h7F80_0000, 0);
      send_dir(32'h7FC0_0000, F_ONE, F_ONE, 3);
      send_dir(F_ONE, 32'hFFA0_0001, 32'h7F80_0001, 0);
      send_dir(32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF, 0);
      send_dir(32'h1E00_0000, 32'h1E00_0000, 32'h9E00_0000, 0);
      send_dir(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 1);
      send_dir(32'h6000_0000, F_ZERO, F_ZERO, 0);
      send_dir(32'h2000_0000, 32'h2000_0000, F_ZERO, 0);
      send_dir(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_dir(32'h3F80_0001, 32'h0080_0000, 32'hBF7F_FFFF, 4);
      for (int i = 0; i < 6; i++)
         send_dir(edge_vals[$urandom_range(0, 15)], edge_vals[$urandom_range(0, 15)],
                  edge_vals[$urandom_range(0, 15)], $urandom_range(0, 2));

      // Random part with quiet stretches, a back-to-back run and one full drain.
      for (int n = 0; n < RandomWords; n++) begin
         gap = ((n / 40) % 3 == 0) ? 0 : $urandom_range(0, 19);
         if (n >= 150 && n < 190) gap = 0;
         if (n == 300) begin
            req_valid <= 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
         send_dir(pick_component(), pick_component(), pick_component(), gap);
      end
      req_valid <= 1'b0;

      wait (pending == 0);
      repeat (30) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Response side: stall a random count per word, and hold off once for a long stretch
   // while the sender keeps offering back to back.
   initial begin
      int stalls, words;
      words = 0;
      @(negedge clock);
      wait (!reset);
      @(negedge clock);
      forever begin
         if (words == HoldAtWord) begin
            stalls = HoldCycles;
         end else begin
            stalls = ((words / 50) % 3 == 1) ? 0 : $urandom_range(0, 19);
         end
         if (stalls > 0) begin
            rsp_stall <= 1'b1;
            repeat (stalls) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         words++;
         @(negedge clock);
      end
   end

   // Watchdog: give up after too many cycles without a word moving on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchLimit) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

endmodule
